/* rtl/autokey_vigenere_cipher_unit_assert.svh */
// Assertion helpers for the cipher unit: clocked on clk, off while arst_n is low.
`ifndef AUTOKEY_VIGENERE_CIPHER_UNIT_ASSERT_SVH
`define AUTOKEY_VIGENERE_CIPHER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AKV_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AKV_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

/* rtl/akv_pkg.sv */
`timescale 1ns / 1ps

package akv_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_LOAD    = 2'd1,
		OP_ENCRYPT = 2'd2,
		OP_DECRYPT = 2'd3
	} op_t;

	localparam logic [1:0] SEL_LATIN    = 2'd0;
	localparam logic [1:0] SEL_CYRILLIC = 2'd1;

	localparam logic [6:0] LAT_BASE = 7'd74;
	localparam logic [6:0] LAT_LEN  = 7'd52;
	localparam logic [6:0] CYR_LEN  = 7'd74;
	localparam logic [6:0] ALL_LEN  = 7'd126;

	// Cyrillic lower, Cyrillic upper, Latin lower, Latin upper
	localparam logic [7:0] ALPHA_CODES [126] = '{
		8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hB4, 8'hE4, 8'hE5, 8'hB8, 8'hBA, 8'hE6, 8'hE7, 8'hE8,
		8'hB3, 8'hBF, 8'hE9, 8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF, 8'hF0, 8'hF1, 8'hF2,
		8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE,
		8'hFF,
		8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hA5, 8'hC4, 8'hC5, 8'hA8, 8'hAA, 8'hC6, 8'hC7, 8'hC8,
		8'hB2, 8'hAF, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD0, 8'hD1, 8'hD2,
		8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
		8'hDF,
		8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C,
		8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
		8'h79, 8'h7A,
		8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C,
		8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
		8'h59, 8'h5A
	};

	typedef struct packed {
		logic       hit;
		logic [6:0] idx;
	} lookup_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       status;
	} result_t;

	// Position of a byte in the full 126-letter table.
	function automatic lookup_t char_index(input logic [7:0] c);
		lookup_t    r;
		logic [7:0] off;
		logic [7:0] pos;
		logic [7:0] up;
		r   = '0;
		off = 8'd0;
		pos = 8'd0;
		up  = 8'd0;
		if (c >= 8'hC0) begin
			up  = (c >= 8'hE0) ? 8'd0 : 8'd37;
			off = {3'b000, c[4:0]};
			if (off <= 8'd3) begin
				pos = off;
			end else if (off <= 8'd5) begin
				pos = off + 8'd1;
			end else if (off <= 8'd8) begin
				pos = off + 8'd3;
			end else begin
				pos = off + 8'd5;
			end
			r.hit = 1'b1;
			r.idx = 7'(pos + up);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.hit = 1'b1;
			r.idx = 7'(c - 8'h61 + 8'd74);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			r.hit = 1'b1;
			r.idx = 7'(c - 8'h41 + 8'd100);
		end else begin
			case (c)
				8'hB4: begin r.hit = 1'b1; r.idx = 7'd4;  end
				8'hB8: begin r.hit = 1'b1; r.idx = 7'd7;  end
				8'hBA: begin r.hit = 1'b1; r.idx = 7'd8;  end
				8'hB3: begin r.hit = 1'b1; r.idx = 7'd12; end
				8'hBF: begin r.hit = 1'b1; r.idx = 7'd13; end
				8'hA5: begin r.hit = 1'b1; r.idx = 7'd41; end
				8'hA8: begin r.hit = 1'b1; r.idx = 7'd44; end
				8'hAA: begin r.hit = 1'b1; r.idx = 7'd45; end
				8'hB2: begin r.hit = 1'b1; r.idx = 7'd49; end
				8'hAF: begin r.hit = 1'b1; r.idx = 7'd50; end
				default: r = '0;
			endcase
		end
		return r;
	endfunction

endpackage

/* rtl/akv_key_store.sv */
`timescale 1ns / 1ps

module akv_key_store import akv_pkg::*; #(
	parameter int KEY_DEPTH = 64,
	parameter int ADDR_W    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [6:0]        wr_data,
	output logic [6:0]        rd_data
);

	logic [6:0] mem_q [KEY_DEPTH];
	logic [6:0] rd_q;
	logic       fwd_hit_q;
	logic [6:0] fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
		fwd_data_q <= wr_data;
	end

	// A write landing on the same edge as the read leaves the array stale: bypass it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

/* rtl/akv_out_fifo.sv */
`timescale 1ns / 1ps

module akv_out_fifo import akv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  result_t    push_data,
	input  logic       pop,
	output logic       valid,
	output result_t    head,
	output logic [1:0] occ
);

	result_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] occ_q;
	logic       pop_fire;

	assign valid    = (occ_q != 2'd0);
	assign pop_fire = pop && valid;
	assign head     = ent_q[rd_ptr_q];
	assign occ      = occ_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_fire) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			occ_q <= occ_q + {1'b0, push} - {1'b0, pop_fire};
		end
	end

endmodule

/* rtl/autokey_vigenere_cipher_unit.sv */
// Autokey Vigenere cipher unit.
// Input channel (in_valid/in_ready) carries an operation and a byte: clear key,
// load a key byte, encrypt or decrypt. Output channel (out_valid/out_ready)
// carries out_char and status; status 1 means the key store was empty and the
// byte passed unchanged. Clears, loads and bytes outside the current alphabet
// give no result beat.
// Throughput: one input beat per cycle, sustained, while the receiver takes
// results. A result passes through the key memory's registered read, then one
// stage of modular add/subtract, code lookup and key write-back, and is
// registered into the output buffer before it is offered; a write-back that
// meets a read of the same entry is forwarded.
// A two-entry output buffer lets input beats continue while a result waits; when the
// receiver stalls with the buffer full, or with one entry and a result in stage 1, in_ready drops.
// Reset: key store empty, pointers zero, Latin alphabet selected. The key
// memory needs no clearing pass. cfg_we/cfg_wdata write the alphabet selector;
// write it only while the block is idle.
`timescale 1ns / 1ps
`include "autokey_vigenere_cipher_unit_assert.svh"

module autokey_vigenere_cipher_unit import akv_pkg::*; #(
	parameter int KEY_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       status
);

	localparam int ADDR_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int CNT_W  = $clog2(KEY_DEPTH + 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(KEY_DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(KEY_DEPTH);

	logic [1:0]        alphabet_select_q;
	logic [ADDR_W-1:0] head_q;
	logic [ADDR_W-1:0] tail_q;
	logic [CNT_W-1:0]  key_count_q;

	op_t        op_in;
	lookup_t    look;
	logic       hit_s0;
	logic [6:0] widx_s0;
	logic [6:0] len;
	logic [6:0] base;
	logic       in_fire;
	logic       out_fire;
	logic       is_keyop;
	logic       has_key;
	logic       rd_en;
	logic       load_ok;
	logic       nokey_s0;

	logic              wr_s1;
	logic              keyop_s1;
	logic              nokey_s1;
	logic              dec_s1;
	logic [6:0]        idx_s1;
	logic [7:0]        ch_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic [6:0] key_raw;
	logic [7:0] len8;
	logic [7:0] key8;
	logic [7:0] kred;
	logic [7:0] idx8;
	logic [7:0] sum;
	logic [7:0] enc_res;
	logic [7:0] dec_res;
	logic [6:0] res7;
	logic [6:0] plain7;
	logic [6:0] wr_data;
	logic [6:0] code_idx;
	logic       push_s1;
	result_t    push_data;
	result_t    head_res;
	logic [1:0] occ;

	function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p);
		return (p == LAST_ADDR) ? '0 : p + 1'b1;
	endfunction

	// Alphabet window
	always_comb begin
		case (alphabet_select_q)
			SEL_LATIN: begin
				len  = LAT_LEN;
				base = LAT_BASE;
			end
			SEL_CYRILLIC: begin
				len  = CYR_LEN;
				base = 7'd0;
			end
			default: begin
				len  = ALL_LEN;
				base = 7'd0;
			end
		endcase
	end

	assign op_in = op_t'(operation);
	assign look  = char_index(in_char);

	always_comb begin
		case (alphabet_select_q)
			SEL_LATIN: begin
				hit_s0  = look.hit && (look.idx >= LAT_BASE);
				widx_s0 = look.idx - LAT_BASE;
			end
			SEL_CYRILLIC: begin
				hit_s0  = look.hit && (look.idx < CYR_LEN);
				widx_s0 = look.idx;
			end
			default: begin
				hit_s0  = look.hit;
				widx_s0 = look.idx;
			end
		endcase
	end

	assign out_fire = out_valid && out_ready;
	assign in_ready = ((occ + {1'b0, push_s1}) <= 2'd1) || out_fire;
	assign in_fire  = in_valid && in_ready;
	assign is_keyop = (op_in == OP_ENCRYPT) || (op_in == OP_DECRYPT);
	assign has_key  = (key_count_q != '0);
	assign rd_en    = in_fire && is_keyop && hit_s0 && has_key;
	assign nokey_s0 = in_fire && is_keyop && hit_s0 && !has_key;
	assign load_ok  = in_fire && (op_in == OP_LOAD) && hit_s0 && (key_count_q != FULL_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_select_q <= SEL_LATIN;
		end else if (cfg_we) begin
			alphabet_select_q <= cfg_wdata;
		end
	end

	// Pointers move at acceptance; the key values are written in the following cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			key_count_q <= '0;
		end else if (in_fire) begin
			unique case (op_in)
				OP_CLEAR: begin
					head_q      <= '0;
					tail_q      <= '0;
					key_count_q <= '0;
				end
				OP_LOAD: begin
					if (load_ok) begin
						tail_q      <= wrap_inc(tail_q);
						key_count_q <= key_count_q + 1'b1;
					end
				end
				OP_ENCRYPT, OP_DECRYPT: begin
					// pop and push together: count holds
					if (rd_en) begin
						head_q <= wrap_inc(head_q);
						tail_q <= wrap_inc(tail_q);
					end
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1    <= 1'b0;
			keyop_s1 <= 1'b0;
			nokey_s1 <= 1'b0;
		end else begin
			wr_s1    <= load_ok || rd_en;
			keyop_s1 <= rd_en;
			nokey_s1 <= nokey_s0;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1     <= (op_in == OP_DECRYPT);
		idx_s1     <= widx_s0;
		ch_s1      <= in_char;
		wr_addr_s1 <= tail_q;
	end

	akv_key_store #(
		.KEY_DEPTH (KEY_DEPTH),
		.ADDR_W    (ADDR_W)
	) u_key_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (head_q),
		.wr_en   (wr_s1),
		.wr_addr (wr_addr_s1),
		.wr_data (wr_data),
		.rd_data (key_raw)
	);

	// Stage 1: reduce the key to the current alphabet, then add or subtract
	always_comb begin
		len8 = {1'b0, len};
		key8 = {1'b0, key_raw};
		idx8 = {1'b0, idx_s1};
		if (key8 >= {len, 1'b0}) begin
			kred = key8 - {len, 1'b0};
		end else if (key8 >= len8) begin
			kred = key8 - len8;
		end else begin
			kred = key8;
		end
		sum     = idx8 + kred;
		enc_res = (sum >= len8) ? sum - len8 : sum;
		dec_res = (idx8 >= kred) ? idx8 - kred : idx8 + len8 - kred;
		res7    = dec_s1 ? dec_res[6:0] : enc_res[6:0];
		plain7  = dec_s1 ? res7 : idx_s1;
		wr_data = keyop_s1 ? plain7 : idx_s1;
	end

	assign code_idx = base + res7;
	assign push_s1  = keyop_s1 || nokey_s1;

	always_comb begin
		push_data.status   = nokey_s1;
		push_data.out_char = nokey_s1 ? ch_s1 : ALPHA_CODES[code_idx];
	end

	akv_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_s1),
		.push_data (push_data),
		.pop       (out_ready),
		.valid     (out_valid),
		.head      (head_res),
		.occ       (occ)
	);

	assign out_char = head_res.out_char;
	assign status   = head_res.status;

	`AKV_ASSERT_NEXT(a_clear_empties, in_fire && op_in == OP_CLEAR, key_count_q == '0 && head_q == '0)
	`AKV_ASSERT_NEXT(a_keyop_keeps_count, rd_en, key_count_q == $past(key_count_q))
	`AKV_ASSERT_NOW(a_out_room, push_s1, occ != 2'd2 || out_fire)

endmodule

/* test/autokey_vigenere_cipher_unit_checker.sv */
`timescale 1ns / 1ps

module autokey_vigenere_cipher_unit_checker import akv_pkg::*; #(
	parameter int KEY_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] in_char,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_char,
	input  logic       status,
	output int         fail_count,
	output int         pending
);

	logic [6:0]  key_ring [KEY_DEPTH];
	int unsigned ring_head;
	int unsigned ring_count;
	logic [1:0]  alphabet;
	result_t     cipher_q [$];
	int          errors = 0;

	// Autokey feed: drop the index when the ring is full.
	function automatic void push_key(input int unsigned idx);
		if (ring_count < KEY_DEPTH) begin
			key_ring[(ring_head + ring_count) % KEY_DEPTH] = idx[6:0];
			ring_count++;
		end
	endfunction

	// Advance the key ring by one input beat; returns 1 when a result beat follows.
	function automatic bit cipher_step(input op_t op, input logic [7:0] c, output result_t res);
		int unsigned base;
		int unsigned len;
		int unsigned i;
		int unsigned key;
		int unsigned plain;
		int unsigned code;
		int          found;
		res = '0;
		if (op == OP_CLEAR) begin
			ring_head  = 0;
			ring_count = 0;
			return 1'b0;
		end
		case (alphabet)
			SEL_LATIN: begin
				base = LAT_BASE;
				len  = LAT_LEN;
			end
			SEL_CYRILLIC: begin
				base = 0;
				len  = CYR_LEN;
			end
			default: begin
				base = 0;
				len  = ALL_LEN;
			end
		endcase
		found = -1;
		for (i = 0; i < len; i++)
			if (found < 0 && ALPHA_CODES[base + i] == c)
				found = i;
		if (found < 0)
			return 1'b0;
		if (op == OP_LOAD) begin
			push_key(found);
			return 1'b0;
		end
		if (ring_count == 0) begin
			res.out_char = c;
			res.status   = 1'b1;
			return 1'b1;
		end
		// stored index may come from a longer alphabet: reduce it first
		key        = key_ring[ring_head] % len;
		ring_head  = (ring_head + 1) % KEY_DEPTH;
		ring_count--;
		if (op == OP_ENCRYPT) begin
			plain = found;
			code  = (plain + key) % len;
		end else begin
			plain = (found + len - key) % len;
			code  = plain;
		end
		push_key(plain);
		res.out_char = ALPHA_CODES[base + code];
		res.status   = 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t predicted;
		result_t oldest;
		if (!arst_n) begin
			alphabet   = SEL_LATIN;
			ring_head  = 0;
			ring_count = 0;
			cipher_q.delete();
		end else begin
			if (cfg_we)
				alphabet = cfg_wdata;
			if (in_valid && in_ready && cipher_step(op_t'(operation), in_char, predicted))
				cipher_q.insert(cipher_q.size(), predicted);
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result beat: char %h status %b",
							$realtime, out_char, status);
				end else begin
					oldest = cipher_q.pop_front();
					if (out_char !== oldest.out_char || status !== oldest.status) begin
						errors++;
						if (errors <= 10)
							$display("%0t: result mismatch: char %h/%h status %b/%b (exp/got)",
								$realtime, oldest.out_char, out_char, oldest.status, status);
					end
				end
			end
		end
		pending    <= cipher_q.size();
		fail_count <= errors;
	end

endmodule

/* test/autokey_vigenere_cipher_unit_tb.sv */
`timescale 1ns / 1ps

module autokey_vigenere_cipher_unit_tb;
	import akv_pkg::*;

	localparam logic [1:0] SEL_BOTH     = 2'd2;
	localparam logic [1:0] SEL_BOTH_ALT = 2'd3;
	localparam int         STALL_LIMIT  = 3000;
	localparam int         HOLD_CYCLES  = 250;
	localparam int         PHASE_ITEMS  = 140;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_wdata = SEL_LATIN;
	logic       in_valid  = 1'b0;
	op_t        operation = OP_CLEAR;
	logic [7:0] in_char   = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_char;
	logic       status;

	int         fail_count;
	int         pending;
	logic [1:0] cur_alphabet = SEL_LATIN;
	int         items_sent   = 0;
	bit         gapless      = 1'b0;
	int         hold_asks    = 0;
	int         hold_served  = 0;
	int         idle_cycles  = 0;

	autokey_vigenere_cipher_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.in_char  (in_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char (out_char),
		.status   (status)
	);

	autokey_vigenere_cipher_unit_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.in_char   (in_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.status    (status),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] random_letter(input logic [1:0] sel);
		case (sel)
			SEL_LATIN:    return ALPHA_CODES[LAT_BASE + $urandom_range(0, LAT_LEN - 1)];
			SEL_CYRILLIC: return ALPHA_CODES[$urandom_range(0, CYR_LEN - 1)];
			default:      return ALPHA_CODES[$urandom_range(0, ALL_LEN - 1)];
		endcase
	endfunction

	task automatic send_beat(input op_t op, input logic [7:0] ch);
		int gap;
		in_valid  <= 1'b1;
		operation <= op;
		in_char   <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		gap = gapless ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every result has come back and the pipeline has emptied.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_alphabet(input logic [1:0] sel);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= sel;
		@(posedge clk);
		cfg_we       <= 1'b0;
		cur_alphabet = sel;
	endtask

	// Key load followed by text, with some stray bytes mixed in.
	task automatic run_session(input int n_keys, input int n_text);
		int  i;
		op_t op;
		if ($urandom_range(0, 3) == 0) begin
			send_beat(OP_CLEAR, 8'($urandom));
		end
		for (i = 0; i < n_keys; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_beat(OP_LOAD, 8'($urandom));
			end else begin
				send_beat(OP_LOAD, random_letter(cur_alphabet));
			end
		end
		for (i = 0; i < n_text; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_beat(op_t'(2'($urandom)), 8'($urandom));
			end else begin
				op = $urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT;
				send_beat(op, random_letter(cur_alphabet));
			end
		end
	endtask

	initial begin
		logic [1:0] plan [6];
		int         ph;
		plan = '{SEL_LATIN, SEL_CYRILLIC, SEL_BOTH, SEL_BOTH_ALT, SEL_CYRILLIC, SEL_LATIN};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store passes bytes through
		send_beat(OP_ENCRYPT, "a");
		send_beat(OP_DECRYPT, "Z");
		// loads outside the Latin set are ignored
		send_beat(OP_LOAD, 8'h00);
		send_beat(OP_LOAD, 8'hFF);
		send_beat(OP_LOAD, "a");
		send_beat(OP_LOAD, "Z");
		send_beat(OP_LOAD, "m");
		send_beat(OP_ENCRYPT, "Z");
		send_beat(OP_ENCRYPT, "z");
		send_beat(OP_DECRYPT, "a");
		send_beat(OP_ENCRYPT, 8'h7B);
		send_beat(OP_DECRYPT, 8'h40);
		send_beat(OP_ENCRYPT, "A");
		send_beat(OP_DECRYPT, 8'hE0);
		send_beat(OP_CLEAR, 8'hFF);
		send_beat(OP_ENCRYPT, "q");
		send_beat(OP_LOAD, "b");
		send_beat(OP_CLEAR, 8'h00);
		send_beat(OP_DECRYPT, "b");

		for (ph = 0; ph < 6; ph++) begin
			// keys are kept across the switch so stored indices meet a new length
			write_alphabet(plan[ph]);
			if (ph == 1 || ph == 4)
				run_session(70, 10);
			if (ph == 2) begin
				hold_asks++;
				gapless = 1'b1;
				run_session(4, 40);
				gapless = 1'b0;
			end
			while (items_sent < (ph + 1) * PHASE_ITEMS) begin
				gapless = ($urandom_range(0, 5) == 0);
				run_session($urandom_range(0, 5), $urandom_range(1, 20));
			end
			gapless = 1'b0;
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Result side: random ready, plus one long hold-off on request.
	initial begin
		int on_len;
		int off_len;
		int k;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_asks != hold_served) begin
				hold_served = hold_asks;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= 1'b1;
			on_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
			for (k = 0; k < on_len && hold_asks == hold_served; k++)
				@(posedge clk);
			off_len = pick_gap();
			if (off_len > 0 && hold_asks == hold_served) begin
				out_ready <= 1'b0;
				for (k = 0; k < off_len && hold_asks == hold_served; k++)
					@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

/* autokey_vigenere_cipher_unit.f */
+incdir+rtl
rtl/akv_pkg.sv
rtl/akv_key_store.sv
rtl/akv_out_fifo.sv
rtl/autokey_vigenere_cipher_unit.sv
test/autokey_vigenere_cipher_unit_checker.sv
test/autokey_vigenere_cipher_unit_tb.sv
